[sv/bfss_pkg.sv]
// Shared types and constants for the Bloom-filtered small set.
package bfss_pkg;

	localparam int DATA_W          = 32;
	localparam int CAP_W           = 7;
	localparam int COUNT_W         = 7;
	localparam int MASK_W          = 64;
	localparam int MAX_ENTRIES_DEF = 64;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic CMD_CHECK  = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] key;
	} scan_req_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_res_t;

endpackage

[sv/bfss_ram.sv]
// Generic simple dual-port RAM with registered read.
module bfss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[sv/bfss_scan.sv]
// Entry store and sequential compare scan, one entry per cycle.
module bfss_scan #(
	parameter int DEPTH = bfss_pkg::MAX_ENTRIES_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfss_pkg::scan_req_t           req,
	input  logic [CW-1:0]                 num,
	input  logic                          wr_en,
	input  logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  logic [bfss_pkg::DATA_W-1:0]   wr_data,
	output bfss_pkg::scan_res_t           res
);

	localparam int AW = $clog2(DEPTH);

	logic                        busy_q;
	logic [CW-1:0]               idx_q;
	logic [CW-1:0]               num_q;
	logic [bfss_pkg::DATA_W-1:0] key_q;
	logic                        pend_s1;
	logic [bfss_pkg::DATA_W-1:0] rd_data;
	logic                        match;
	logic                        exhausted;
	logic                        issue;

	assign match     = pend_s1 && (rd_data == key_q);
	assign exhausted = !pend_s1 && (idx_q >= num_q);
	assign issue     = busy_q && !match && (idx_q < num_q);

	bfss_ram #(
		.WIDTH(bfss_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (issue),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pend_s1 <= 1'b0;
			idx_q   <= '0;
		end else if (req.start) begin
			busy_q  <= 1'b1;
			pend_s1 <= 1'b0;
			idx_q   <= '0;
		end else if (busy_q) begin
			if (match || exhausted) begin
				busy_q  <= 1'b0;
				pend_s1 <= 1'b0;
			end else begin
				pend_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= num;
			key_q <= req.key;
		end
	end

	assign res.done  = busy_q && (match || exhausted);
	assign res.found = match;

endmodule

[sv/bloom_filtered_small_set.sv]
// Top level of the Bloom-filtered small set: control, masks, count and result register.
//
// Usage:
//   s_* carries one transaction per item: s_tuser[0] is the command (0 check,
//   1 insert), s_tdata[31:0] the signed value. m_* returns exactly one result
//   transaction per item. cfg_* writes capacity_in_use (7 bits); it is always
//   ready and should be written only while the block is idle.
//   When the Bloom masks miss, an accepted item goes straight to ST_DONE and
//   its result is then loaded into the output register. On a mask hit the
//   stored entries are read from the entry RAM and compared one per cycle,
//   stopping at the first match; the single RAM read port and the one
//   comparator set this rate. s_tready is high only when no item is in
//   progress.
//   A finished result waits in the output register; the next item is taken
//   meanwhile, but its result is held back until the register is free, so a
//   stalled receiver eventually stalls the input.
//   Reset clears count, masks and output valid and sets capacity to 64; the
//   entry RAM is not cleared, as only written entries are ever read.
module bloom_filtered_small_set #(
	parameter int MAX_ENTRIES = bfss_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [0:0]  s_tuser,   // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] present, [1] added, [2] full_res, [9:3] count
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);

	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int AW   = $clog2(MAX_ENTRIES);
	localparam int CMPW = (CW > bfss_pkg::CAP_W) ? CW : bfss_pkg::CAP_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic                          cmd_q;
	logic [bfss_pkg::DATA_W-1:0]   value_q;
	logic [CW-1:0]                 cnt_q;
	logic [bfss_pkg::MASK_W-1:0]   mask_lo_q;
	logic [bfss_pkg::MASK_W-1:0]   mask_hi_q;
	logic [bfss_pkg::CAP_W-1:0]    cap_q;
	logic                          present_q;
	logic                          m_tvalid_q;
	logic                          out_present_q;
	logic                          out_added_q;
	logic                          out_full_q;
	logic [bfss_pkg::COUNT_W-1:0]  out_count_q;

	bfss_pkg::scan_req_t           scan_req;
	bfss_pkg::scan_res_t           scan_res;

	logic                          s_acc;
	logic [5:0]                    in_idx1;
	logic [5:0]                    in_idx2;
	logic [5:0]                    q_idx1;
	logic [5:0]                    q_idx2;
	logic                          hit;
	logic [CMPW-1:0]               cap_ext;
	logic [CMPW-1:0]               cap_eff;
	logic [CMPW-1:0]               cnt_ext;
	logic                          room;
	logic                          out_free;
	logic                          finish;
	logic                          add_w;
	logic                          full_w;
	logic [CMPW-1:0]               cnt_next_ext;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign in_idx1 = s_tdata[5:0];
	assign in_idx2 = s_tdata[11:6] + s_tdata[5:0];
	assign q_idx1  = value_q[5:0];
	assign q_idx2  = value_q[11:6] + value_q[5:0];
	assign hit     = mask_lo_q[in_idx1] && mask_hi_q[in_idx2];

	assign cap_ext = CMPW'(cap_q);
	assign cap_eff = (cap_ext > CMPW'(MAX_ENTRIES)) ? CMPW'(MAX_ENTRIES) : cap_ext;
	assign cnt_ext = CMPW'(cnt_q);
	assign room    = cnt_ext < cap_eff;

	assign out_free     = !m_tvalid_q || m_tready;
	assign finish       = (state_q == ST_DONE) && out_free;
	assign add_w        = finish && (cmd_q == bfss_pkg::CMD_INSERT) && !present_q && room;
	assign full_w       = (cmd_q == bfss_pkg::CMD_INSERT) && !present_q && !room;
	assign cnt_next_ext = cnt_ext + CMPW'(add_w);

	assign scan_req.start = s_acc && hit;
	assign scan_req.key   = s_tdata;

	bfss_scan #(
		.DEPTH(MAX_ENTRIES),
		.CW   (CW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (scan_req),
		.num    (cnt_q),
		.wr_en  (add_w),
		.wr_addr(cnt_q[AW-1:0]),
		.wr_data(value_q),
		.res    (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			mask_lo_q     <= '0;
			mask_hi_q     <= '0;
			cap_q         <= bfss_pkg::CAP_RESET;
			m_tvalid_q    <= 1'b0;
			out_present_q <= 1'b0;
			out_added_q   <= 1'b0;
			out_full_q    <= 1'b0;
			out_count_q   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (m_tvalid_q && m_tready && !finish) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= hit ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (scan_res.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q    <= 1'b1;
						state_q       <= ST_IDLE;
						out_present_q <= present_q;
						out_added_q   <= add_w;
						out_full_q    <= full_w;
						out_count_q   <= cnt_next_ext[bfss_pkg::COUNT_W-1:0];
						if (add_w) begin
							cnt_q             <= cnt_q + CW'(1);
							mask_lo_q[q_idx1] <= 1'b1;
							mask_hi_q[q_idx2] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_q     <= s_tuser[0];
			value_q   <= s_tdata;
			present_q <= 1'b0;
		end else if ((state_q == ST_SCAN) && scan_res.done) begin
			present_q <= scan_res.found;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, out_count_q, out_full_q, out_added_q, out_present_q};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMPW'(cnt_q) <= CMPW'(MAX_ENTRIES))
		else $error("entry count exceeds store depth");

	a_add_incr: assert property (@(posedge clk) disable iff (!arst_n)
		add_w |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("count did not advance on insert");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(out_added_q && out_full_q) && !(out_present_q && out_added_q))
		else $error("conflicting result flags");

	a_scan_idle: assert property (@(posedge clk) disable iff (!arst_n)
		scan_res.done |-> (state_q == ST_SCAN))
		else $error("scan finished outside scan state");

endmodule
